@@ src/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants of the call-site census block.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int          MAX_SITES_DEF     = 24;
    localparam logic [7:0]  CALL_OPCODE       = 8'hE8;
    localparam logic [15:0] REPORT_FRAMES_RST = 16'd200;
    localparam int          WINDOW_DEPTH      = 4;

    localparam int          PADDR_W           = 4;
    localparam logic [1:0]  REG_TARGET        = 2'd0;
    localparam logic [1:0]  REG_IMAGE_BASE    = 2'd1;
    localparam logic [1:0]  REG_REPORT_FRAMES = 2'd2;

    localparam logic        REC_SUMMARY       = 1'b0;
    localparam logic        REC_SITE          = 1'b1;

    typedef enum logic [1:0] {
        OP_SCAN   = 2'd0,
        OP_FINISH = 2'd1,
        OP_CALL   = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK,
        ST_FLUSH
    } t_census_state;

    typedef struct packed {
        t_op         operation;
        logic [31:0] byte_address;
        logic [7:0]  byte_value;
        logic [31:0] call_return;
    } t_in_item;

    typedef struct packed {
        logic        record_kind;
        logic [5:0]  site_index;
        logic [31:0] site_offset;
        logic [31:0] call_count;
        logic [31:0] unmatched_count;
        logic [15:0] frame_count;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic        hit;
        logic [31:0] ret;
    } t_scan_hit;

endpackage

@@ src/csc_scan.sv @@
// ----------------------------------------------------------------------------
// csc_scan
// Code byte window: flags a near call whose target is the watched function.
// ----------------------------------------------------------------------------
module csc_scan import csc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_scan,
    input  logic        i_finish,
    input  logic [31:0] i_byte_address,
    input  logic [7:0]  i_byte_value,
    input  logic [31:0] i_target_address,
    output t_scan_hit   o_hit
);

    logic [7:0]  r_win [WINDOW_DEPTH];
    logic [2:0]  r_fill;
    logic [2:0]  n_fill;
    logic [31:0] disp;
    logic [31:0] ret;

    assign disp = {i_byte_value, r_win[3], r_win[2], r_win[1]};
    assign ret  = i_byte_address + 32'd1;

    always_comb begin
        o_hit.ret = ret;
        o_hit.hit = (r_fill >= 3'(WINDOW_DEPTH)) && (r_win[0] == CALL_OPCODE)
                    && ((ret + disp) == i_target_address);
    end

    always_comb begin
        n_fill = r_fill;
        if (i_finish) begin
            n_fill = '0;
        end else if (i_scan && r_fill < 3'(WINDOW_DEPTH)) begin
            n_fill = r_fill + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_fill <= n_fill;
            if (i_scan) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= r_win[3];
                r_win[3] <= i_byte_value;
            end
        end
    end

endmodule

@@ src/csc_census.sv @@
// ----------------------------------------------------------------------------
// csc_census
// Site table and counter memories, call matching, report sequencer.
// ----------------------------------------------------------------------------
module csc_census import csc_pkg::*; #(
    parameter int MAX_SITES = MAX_SITES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in_item    i_item,
    input  t_scan_hit   i_hit,
    input  logic [31:0] i_target_address,
    input  logic [31:0] i_image_base,
    input  logic [15:0] i_report_frames,
    output logic        o_busy,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    localparam int IDX_W = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int SF_W  = $clog2(MAX_SITES + 1);

    logic [31:0]   ret_mem [MAX_SITES];
    logic [31:0]   cnt_mem [MAX_SITES];

    t_census_state r_state, n_state;
    logic          r_armed, n_armed;
    logic [SF_W-1:0]  r_sites, n_sites;
    logic [31:0]   r_total, n_total;
    logic [31:0]   r_unmatched, n_unmatched;
    logic [15:0]   r_frames, n_frames;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [31:0]   r_key, n_key;
    t_out_item     r_pend, n_pend;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out_data, n_out_data;
    logic [31:0]   r_ret_rd;
    logic [31:0]   r_cnt_rd;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic          ret_we;
    logic          cnt_we;
    logic [31:0]   cnt_wdata;
    logic          out_free;
    logic          push;
    t_out_item     push_data;
    logic          last_idx;
    logic [15:0]   frames_inc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign last_idx   = (SF_W'(r_idx) + SF_W'(1)) == r_sites;
    assign frames_inc = r_frames + 16'd1;
    assign o_busy     = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_armed     = r_armed;
        n_sites     = r_sites;
        n_total     = r_total;
        n_unmatched = r_unmatched;
        n_frames    = r_frames;
        n_idx       = r_idx;
        n_key       = r_key;
        n_pend      = r_pend;
        rd_addr     = r_idx;
        wr_addr     = r_idx;
        ret_we      = 1'b0;
        cnt_we      = 1'b0;
        cnt_wdata   = '0;
        push        = 1'b0;
        push_data   = r_pend;
        unique case (r_state)
            ST_IDLE: begin
                rd_addr = '0;
                if (i_accept) begin
                    unique case (i_item.operation)
                        OP_SCAN: begin
                            if (i_hit.hit && r_sites < SF_W'(MAX_SITES)) begin
                                ret_we  = 1'b1;
                                cnt_we  = 1'b1;
                                wr_addr = r_sites[IDX_W-1:0];
                                n_sites = r_sites + SF_W'(1);
                            end
                        end
                        OP_FINISH: begin
                            if (i_target_address != '0 && r_sites != '0) begin
                                n_armed = 1'b1;
                            end
                        end
                        OP_CALL: begin
                            if (r_armed) begin
                                n_total = r_total + 32'd1;
                                if (r_sites == '0) begin
                                    n_unmatched = r_unmatched + 32'd1;
                                end else begin
                                    n_key   = i_item.call_return;
                                    n_idx   = '0;
                                    n_state = ST_SEARCH;
                                end
                            end
                        end
                        OP_TICK: begin
                            if (r_armed) begin
                                n_frames = frames_inc;
                                if (frames_inc >= i_report_frames) begin
                                    n_pend.record_kind     = REC_SUMMARY;
                                    n_pend.site_index      = '0;
                                    n_pend.site_offset     = '0;
                                    n_pend.call_count      = r_total;
                                    n_pend.unmatched_count = r_unmatched;
                                    n_pend.frame_count     = frames_inc;
                                    n_pend.last            = 1'b0;
                                    n_idx   = '0;
                                    n_state = (r_sites == '0) ? ST_FLUSH : ST_CHECK;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (r_ret_rd == r_key) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = r_cnt_rd + 32'd1;
                    n_state   = ST_IDLE;
                end else if (last_idx) begin
                    n_unmatched = r_unmatched + 32'd1;
                    n_state     = ST_IDLE;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    rd_addr = r_idx + IDX_W'(1);
                end
            end
            ST_CHECK: begin
                if (r_cnt_rd == '0 || out_free) begin
                    if (r_cnt_rd != '0) begin
                        push                   = 1'b1;
                        n_pend.record_kind     = REC_SITE;
                        n_pend.site_index      = 6'(r_idx);
                        n_pend.site_offset     = r_ret_rd - i_image_base;
                        n_pend.call_count      = r_cnt_rd;
                        n_pend.unmatched_count = '0;
                        n_pend.frame_count     = r_frames;
                        n_pend.last            = 1'b0;
                    end
                    cnt_we = 1'b1;
                    if (last_idx) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        rd_addr = r_idx + IDX_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    push           = 1'b1;
                    push_data.last = 1'b1;
                    n_total        = '0;
                    n_unmatched    = '0;
                    n_frames       = '0;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (push) begin
            n_out_valid = 1'b1;
            n_out_data  = push_data;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ret_we) begin
            ret_mem[wr_addr] <= i_hit.ret;
        end
        if (cnt_we) begin
            cnt_mem[wr_addr] <= cnt_wdata;
        end
        r_ret_rd <= ret_mem[rd_addr];
        r_cnt_rd <= cnt_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_armed     <= 1'b0;
            r_sites     <= '0;
            r_total     <= '0;
            r_unmatched <= '0;
            r_frames    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_armed     <= n_armed;
            r_sites     <= n_sites;
            r_total     <= n_total;
            r_unmatched <= n_unmatched;
            r_frames    <= n_frames;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_key      <= n_key;
        r_pend     <= n_pend;
        r_out_data <= n_out_data;
    end

endmodule

@@ src/call_site_census_unit.sv @@
// ----------------------------------------------------------------------------
// call_site_census_unit
// Call-site profiler: finds call sites of one function in a code byte stream,
// counts calls per site and reports the counts once per frame window.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_stall o_out_data (t_out_item)
//  config    input      APB write, pready high    paddr, pwdata, prdata
//
//  Scan byte, finish scan and ticks without a report do not stall the input.
//  A call event stalls the input while sites are read in turn from the site
//  memory until the first match (up to the number of sites found).
//  A report reads every site in turn and stalls the input meanwhile, also
//  while a result waits on a stalled output.
//  No clearing pass after reset.
//  A finished result waits in the output register while the next input is taken.
// ----------------------------------------------------------------------------
module call_site_census_unit import csc_pkg::*; #(
    parameter int MAX_SITES = MAX_SITES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [31:0] r_target_address;
    logic [31:0] r_image_base;
    logic [15:0] r_report_frames;
    logic [1:0]  reg_idx;
    logic        cfg_write;
    logic        accept;
    logic        busy;
    t_scan_hit   hit;

    assign reg_idx    = paddr[3:2];
    assign cfg_write  = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    always_comb begin
        unique case (reg_idx)
            REG_TARGET:        prdata = r_target_address;
            REG_IMAGE_BASE:    prdata = r_image_base;
            REG_REPORT_FRAMES: prdata = {16'd0, r_report_frames};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_address <= '0;
            r_image_base     <= '0;
            r_report_frames  <= REPORT_FRAMES_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_TARGET:        r_target_address <= pwdata;
                REG_IMAGE_BASE:    r_image_base     <= pwdata;
                REG_REPORT_FRAMES: r_report_frames  <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    csc_scan u_scan (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_scan           (accept && i_in_data.operation == OP_SCAN),
        .i_finish         (accept && i_in_data.operation == OP_FINISH),
        .i_byte_address   (i_in_data.byte_address),
        .i_byte_value     (i_in_data.byte_value),
        .i_target_address (r_target_address),
        .o_hit            (hit)
    );

    csc_census #(
        .MAX_SITES (MAX_SITES)
    ) u_census (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_item           (i_in_data),
        .i_hit            (hit),
        .i_target_address (r_target_address),
        .i_image_base     (r_image_base),
        .i_report_frames  (r_report_frames),
        .o_busy           (busy),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_data       (o_out_data)
    );

endmodule
